@@ rtl/core/running_median_highpass_unit_assert.svh @@
// Assertion macros shared by the running median high-pass RTL.
// Included by modules that check their own sequencing.
`ifndef RUNNING_MEDIAN_HIGHPASS_UNIT_ASSERT_SVH
`define RUNNING_MEDIAN_HIGHPASS_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RMH_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RMH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/rmh_pkg.sv @@
// Package for the running median high-pass unit: sizes, constants and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmh_pkg;
    localparam int MaxChannels = 64;
    localparam int MaxHalfWindow = 15;
    localparam int WinSlots = 2 * MaxHalfWindow + 1;
    localparam int ChW = $clog2(MaxChannels);
    localparam int SlotW = $clog2(WinSlots + 1);
    localparam int AddrW = $clog2(MaxChannels * WinSlots);
    localparam int Depth = MaxChannels * WinSlots;
    localparam int CntW = $clog2(MaxHalfWindow + 2);
    localparam logic [3:0] HalfWindowReset = 4'd10;
    localparam int DataW = 16;

    typedef logic [SlotW-1:0] slot_t;
    typedef logic [AddrW-1:0] addr_t;
    typedef logic signed [DataW-1:0] data_t;

    // Flat memory address of one slot of one channel.
    function automatic addr_t slot_addr(input logic [ChW-1:0] ch, input slot_t s);
        logic [AddrW+SlotW:0] full;
        full = (AddrW+SlotW+1)'(ch) * (AddrW+SlotW+1)'(WinSlots)
            + (AddrW+SlotW+1)'(s);
        return full[AddrW-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/running_median_highpass_unit.sv @@
// Running median high-pass unit: top level with sequencer and memories.
// Depends on rmh_pkg, rmh_ram and running_median_highpass_unit_assert.svh.
//
// Usage: one signed 16-bit sample and its channel enter as one beat on the
// sample channel (sample_valid/sample_ready). Per channel the unit keeps a
// delay line and a sorted window of 2W+1 samples, W from half_window. The
// first W beats of a channel give no result; each later beat gives one beat
// on the result channel: the sample W steps back minus the window median,
// wrapped to 16 bits.
// Cost per item: one pass over the channel's sorted window in memory, one
// slot a cycle through the shared compare unit. A new sample is taken only
// when the unit is idle again after the last one.
// The result register holds a finished beat while the receiver stalls. The
// next sample is still accepted; it waits in its last step until the result
// register is free.
// Reset, and every write of half_window, starts a clearing pass that zeroes
// all 1984 slots of the delay and sorted memories, and the channel records,
// one slot a cycle, during which no sample is accepted. Configuration beats
// are always accepted and belong only at times when no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none
module running_median_highpass_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [3:0]           half_window,
    input  wire logic                 sample_valid,
    output logic                      sample_ready,
    input  wire logic signed [15:0]   sample,
    input  wire logic [5:0]           channel,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic signed [15:0]        filtered,
    output logic [5:0]                out_channel
);
    import rmh_pkg::*;
    `include "running_median_highpass_unit_assert.svh"

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DRD   = 4'd2;
    localparam logic [3:0] S_DWT   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_MRD   = 4'd6;
    localparam logic [3:0] S_MWT   = 4'd7;
    localparam logic [3:0] S_CRD   = 4'd8;
    localparam logic [3:0] S_CWT   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        hw_reg;
    logic [AddrW-1:0]  clr_reg;
    data_t             x_reg;
    logic [ChW-1:0]    ch_reg;
    data_t             old_reg;
    slot_t             pos_reg;
    slot_t             idx_reg;
    slot_t             ri_reg;
    logic              found_reg;
    data_t             hold_reg;
    data_t             med_reg;
    data_t             cen_reg;
    data_t             out_reg;
    logic [ChW-1:0]    och_reg;
    logic              ov_reg;
    logic [CntW-1:0]   seen_reg;

    logic [CntW-1:0]   w_eff;
    slot_t             len;
    logic [SlotW:0]    centre_sum;
    slot_t             centre_pos;
    logic              dwe, swe, mwe;
    addr_t             daddr_w, daddr_r, saddr_w, saddr_r;
    data_t             dwdata, swdata, drdata, srdata;
    logic [ChW-1:0]    maddr_w;
    logic [CntW+SlotW-1:0] mwdata, mrdata;
    slot_t             pos_rd;
    logic [CntW-1:0]   seen_rd;
    logic [CntW-1:0]   seen_new;
    slot_t             wpos_new;
    data_t             cur;
    logic              skip_old, hold_first, out_free;

    // Effective half window: zero acts as one, and 15 is the ceiling.
    // The centre slot sits W+1 slots past the oldest one, modulo the window.
    always_comb
    begin
        w_eff      = (hw_reg == 4'd0) ? CntW'(1) : CntW'(hw_reg);
        len        = SlotW'({w_eff, 1'b1});
        centre_sum = {1'b0, pos_reg} + (SlotW+1)'(w_eff) + (SlotW+1)'(1);
        centre_pos = (centre_sum >= {1'b0, len})
            ? SlotW'(centre_sum - {1'b0, len}) : SlotW'(centre_sum);
    end

    rmh_ram #(.Width(DataW), .Depth(Depth)) u_delay (
        .clk(clk), .we(dwe), .waddr(daddr_w), .wdata(dwdata),
        .raddr(daddr_r), .rdata(drdata));
    rmh_ram #(.Width(DataW), .Depth(Depth)) u_sorted (
        .clk(clk), .we(swe), .waddr(saddr_w), .wdata(swdata),
        .raddr(saddr_r), .rdata(srdata));
    // Per-channel sample count and oldest slot, read as a sample is accepted.
    rmh_ram #(.Width(CntW+SlotW), .Depth(MaxChannels)) u_meta (
        .clk(clk), .we(mwe), .waddr(maddr_w), .wdata(mwdata),
        .raddr(channel), .rdata(mrdata));

    assign cfg_ready    = 1'b1;
    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = ov_reg;
    assign filtered     = out_reg;
    assign out_channel  = och_reg;
    assign out_free     = !ov_reg || result_ready;

    // Channel bookkeeping, read back and updated once per item.
    assign seen_rd  = mrdata[CntW+SlotW-1:SlotW];
    assign pos_rd   = (mrdata[SlotW-1:0] >= len) ? '0 : mrdata[SlotW-1:0];
    assign seen_new = (seen_reg < w_eff + CntW'(1)) ? seen_reg + CntW'(1) : seen_reg;
    assign wpos_new = (pos_reg + SlotW'(1) == len) ? '0 : pos_reg + SlotW'(1);

    // Shared compare unit over the sorted window. One copy of the leaving
    // value is dropped; every other entry is merged with the held value,
    // the smaller one written out and the larger one held for later.
    assign cur        = srdata;
    assign skip_old   = !found_reg && (cur == old_reg);
    assign hold_first = (hold_reg <= cur);

    // Memory port control.
    always_comb
    begin
        dwe = 1'b0; swe = 1'b0; mwe = 1'b0;
        daddr_w = slot_addr(ch_reg, pos_reg);
        daddr_r = slot_addr(ch_reg, pos_reg);
        saddr_w = slot_addr(ch_reg, idx_reg);
        saddr_r = slot_addr(ch_reg, ri_reg);
        dwdata  = x_reg;
        swdata  = x_reg;
        maddr_w = ch_reg;
        mwdata  = {seen_new, wpos_new};
        unique case (state_reg)
            S_CLEAR:
            begin
                dwe = 1'b1; swe = 1'b1; mwe = 1'b1;
                daddr_w = clr_reg; saddr_w = clr_reg;
                dwdata = '0; swdata = '0;
                maddr_w = clr_reg[ChW-1:0];
                mwdata  = '0;
            end
            S_DRD:
            begin
                daddr_r = slot_addr(ch_reg, pos_rd);
            end
            S_SCAN:
            begin
                // Every entry but the dropped one yields one output slot.
                if (!skip_old)
                begin
                    swe = 1'b1;
                    swdata = hold_first ? hold_reg : cur;
                end
            end
            S_WB:
            begin
                dwe = 1'b1;
                swe = 1'b1;
                swdata = hold_reg;
            end
            S_MRD:
            begin
                saddr_r = slot_addr(ch_reg, SlotW'(w_eff));
            end
            S_CRD:
            begin
                daddr_r = slot_addr(ch_reg, ri_reg);
            end
            S_OUT:
            begin
                mwe = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == AddrW'(Depth - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (sample_valid && sample_ready)
                begin
                    state_next = S_DRD;
                end
            end
            S_DRD:  state_next = S_DWT;
            S_DWT:  state_next = S_SCAN;
            S_SCAN: if (ri_reg == len) state_next = S_WB;
            S_WB:   state_next = S_MRD;
            S_MRD:  state_next = S_MWT;
            S_MWT:  state_next = S_CRD;
            S_CRD:  state_next = S_CWT;
            S_CWT:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            hw_reg    <= HalfWindowReset;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
            begin
                ov_reg <= (seen_reg >= w_eff);
            end
            else if (ov_reg && result_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                hw_reg    <= half_window;
                state_reg <= S_CLEAR;
                clr_reg   <= '0;
            end
            else
            begin
                state_reg <= state_next;
                if (state_reg == S_CLEAR)
                begin
                    clr_reg <= clr_reg + AddrW'(1);
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg   <= sample;
                ch_reg  <= channel;
            end
            S_DRD:
            begin
                pos_reg  <= pos_rd;
                seen_reg <= seen_rd;
                ri_reg   <= '0;
            end
            S_DWT:
            begin
                old_reg   <= drdata;
                ri_reg    <= SlotW'(1);
                idx_reg   <= '0;
                found_reg <= 1'b0;
                hold_reg  <= x_reg;
            end
            S_SCAN:
            begin
                if (ri_reg != len)
                begin
                    ri_reg <= ri_reg + SlotW'(1);
                end
                // Entry cur has index ri-1 of the old window.
                if (skip_old)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + SlotW'(1);
                    if (hold_first)
                    begin
                        hold_reg <= cur;
                    end
                end
            end
            S_WB:   ri_reg  <= centre_pos;
            S_MWT:  med_reg <= srdata;
            S_CWT:  cen_reg <= drdata;
            S_OUT:
            begin
                if (out_free)
                begin
                    out_reg <= cen_reg - med_reg;
                    och_reg <= ch_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    `RMH_ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !sample_ready,
        "sample accepted while busy")
    `RMH_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && !result_ready, ov_reg,
        "result dropped while stalled")
    `RMH_ASSERT_IMPLY(a_scan_bound, clk, rst_n, state_reg == S_SCAN, ri_reg <= len,
        "scan ran past window")
endmodule
`default_nettype wire

@@ rtl/core/rmh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rmh_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
